### hdl/ufrc_pkg.sv
// ----------------------------------------------------------------------------
// ufrc_pkg
// Shared types, codes and the CRC-16 byte update for the serial frame
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ufrc_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ODATA_W = 64;

  // Register reset value
  localparam logic [GAP_W-1:0] GAP_TIMEOUT_RST = 16'd50;

  // Framing and CRC constants
  localparam logic [BYTE_W-1:0] SOF1     = 8'hFE;
  localparam logic [BYTE_W-1:0] SOF2     = 8'hFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

  // Input word kinds
  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA   = 3'd0,
    KIND_GOOD   = 3'd1,
    KIND_BADCRC = 3'd2,
    KIND_START  = 3'd3,
    KIND_GAP    = 3'd4
  } kind_t;

  // Receiver phase, one-hot
  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_START2  = 8'b0000_0010,
    PH_ID      = 8'b0000_0100,
    PH_LEN_HI  = 8'b0000_1000,
    PH_LEN_LO  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_HI  = 8'b0100_0000,
    PH_CRC_LO  = 8'b1000_0000
  } phase_t;

  // One input word
  typedef struct packed {
    req_type_t         req_type;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    kind_t             out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  payload_len;
    logic [CRC_W-1:0]  crc_calc;
    logic [CRC_W-1:0]  crc_recv;
    logic              frame_done;
  } result_t;

  // CRC-16, MSB first, one byte unrolled
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int j = 0; j < BYTE_W; j++) begin
      fb = b[BYTE_W-1-j] ^ c[CRC_W-1];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/uart_frame_receiver_crc_check.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_crc_check
// Serial frame receiver with CRC-16 check, streaming in and out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per received byte (in_tuser = 0) or per millisecond tick
//           (in_tuser = 1); the byte rides in in_tdata.
//   out_* : payload bytes as they arrive, then one status word per frame
//           (good, CRC mismatch, start error, gap timeout); out_tlast marks
//           the status word, out_tuser carries its kind.
//   cfg_* : writes the gap timeout in ticks; always ready. Write only while
//           no word is in flight.
// Datapath: a word goes through an input register, combinational parse and
//   CRC update, and a result register, and its result is then offered on
//   out_*. One word is taken every cycle while out_tready is high; the
//   byte-wide CRC update and the phase machine are combinational.
// Reset: rst_n low clears both registers, returns the parser to hunting for
//   the start byte and loads the gap timeout with 50.
// Stall: while out_tready is low the result register holds its word; the
//   input register still fills once, then in_tready drops until the result
//   drains.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_frame_receiver_crc_check
  import ufrc_pkg::*;
#(
  parameter logic [GAP_W-1:0] GAP_TIMEOUT_DEFAULT = GAP_TIMEOUT_RST
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Gap timeout register
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [GAP_W-1:0]   cfg_data,
  // Received words
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [BYTE_W-1:0]  in_tdata,  // [7:0] rx_byte
  input  wire logic               in_tuser,  // [0] req_type
  // Results
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [ODATA_W-1:0]      out_tdata, // [7:0] out_byte, [15:8] frame_id,
                                             // [31:16] payload_len,
                                             // [47:32] crc_calc, [63:48] crc_recv
  output logic [KIND_W-1:0]       out_tuser, // [2:0] out_kind
  output logic                    out_tlast  // frame_done
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  result_t out_res;
  logic    cfg_we;

  assign in_item.req_type = req_type_t'(in_tuser);
  assign in_item.rx_byte  = in_tdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ufrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ufrc_core #(
    .GAP_TIMEOUT_DEFAULT (GAP_TIMEOUT_DEFAULT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  ufrc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_ready (out_tready)
  );

  // Pack result word
  assign out_tdata = {out_res.crc_recv, out_res.crc_calc, out_res.payload_len,
                      out_res.frame_id, out_res.out_byte};
  assign out_tuser = out_res.out_kind;
  assign out_tlast = out_res.frame_done;

endmodule

`default_nettype wire

### hdl/ufrc_in_reg.sv
// ----------------------------------------------------------------------------
// ufrc_in_reg
// Input register: holds one received word until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrc_in_reg
  import ufrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Free slot, or the held word leaves this cycle
  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

### hdl/ufrc_core.sv
// ----------------------------------------------------------------------------
// ufrc_core
// Frame parser: phase machine, header capture, running CRC, gap timer and
// the gap timeout register. Consumes one word per cycle while res_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrc_core
  import ufrc_pkg::*;
#(
  parameter logic [GAP_W-1:0] GAP_TIMEOUT_DEFAULT = GAP_TIMEOUT_RST
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [GAP_W-1:0] cfg_data,
  input  wire logic             item_valid,
  input  wire item_t            item,
  output logic                  item_take,
  output logic                  res_valid,
  output result_t               res,
  input  wire logic             res_ready
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [CRC_W-1:0]  trl_r, trl_nxt;
  logic [GAP_W-1:0]  gap_r, gap_nxt;
  logic [GAP_W-1:0]  timeout_r;
  logic [GAP_W:0]    gap_inc;
  logic [CRC_W-1:0]  crc_upd;
  logic [LEN_W-1:0]  left_dec;
  logic [CRC_W-1:0]  trl_full;
  logic [LEN_W-1:0]  len_full;
  logic              emit;
  result_t           res_c;

  assign item_take = item_valid && res_ready;
  assign gap_inc   = {1'b0, gap_r} + {{GAP_W{1'b0}}, 1'b1};
  assign crc_upd   = crc_byte(crc_r, item.rx_byte);
  assign left_dec  = left_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign trl_full  = {trl_r[CRC_W-1:BYTE_W], item.rx_byte};
  assign len_full  = {len_r[LEN_W-1:BYTE_W], item.rx_byte};

  // Next state and result for the held word
  always_comb begin
    phase_nxt         = phase_r;
    id_nxt            = id_r;
    len_nxt           = len_r;
    left_nxt          = left_r;
    crc_nxt           = crc_r;
    trl_nxt           = trl_r;
    gap_nxt           = gap_r;
    emit              = 1'b0;
    res_c.out_kind    = KIND_DATA;
    res_c.out_byte    = '0;
    res_c.frame_id    = id_r;
    res_c.payload_len = len_r;
    res_c.crc_calc    = '0;
    res_c.crc_recv    = '0;
    res_c.frame_done  = 1'b0;
    if (item.req_type == REQ_TICK) begin
      // Count ticks inside a frame, abort past the timeout
      if (phase_r != PH_HUNT) begin
        if (gap_inc > {1'b0, timeout_r}) begin
          emit             = 1'b1;
          res_c.out_kind   = KIND_GAP;
          res_c.frame_done = 1'b1;
          phase_nxt        = PH_HUNT;
          gap_nxt          = '0;
        end else begin
          gap_nxt = gap_inc[GAP_W-1:0];
        end
      end
    end else begin
      gap_nxt = '0;
      case (phase_r)
        PH_HUNT: begin
          if (item.rx_byte == SOF1) begin
            phase_nxt = PH_START2;
            id_nxt    = '0;
            len_nxt   = '0;
            left_nxt  = '0;
            trl_nxt   = '0;
            crc_nxt   = CRC_INIT;
          end
        end
        PH_START2: begin
          if (item.rx_byte != SOF2) begin
            emit             = 1'b1;
            res_c.out_kind   = KIND_START;
            res_c.frame_done = 1'b1;
            phase_nxt        = PH_HUNT;
          end else begin
            phase_nxt = PH_ID;
          end
        end
        PH_ID: begin
          id_nxt    = item.rx_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {item.rx_byte, {BYTE_W{1'b0}}};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = len_full;
          left_nxt  = len_full;
          phase_nxt = (len_full == '0) ? PH_CRC_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_nxt        = crc_upd;
          left_nxt       = left_dec;
          emit           = 1'b1;
          res_c.out_byte = item.rx_byte;
          if (left_dec == '0) begin
            phase_nxt = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          trl_nxt   = {item.rx_byte, {BYTE_W{1'b0}}};
          phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          trl_nxt          = trl_full;
          emit             = 1'b1;
          res_c.out_kind   = (trl_full == crc_r) ? KIND_GOOD : KIND_BADCRC;
          res_c.crc_calc   = crc_r;
          res_c.crc_recv   = trl_full;
          res_c.frame_done = 1'b1;
          phase_nxt        = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  assign res_valid = item_valid && emit;
  assign res       = res_c;

  // Advance frame state on each consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      id_r    <= '0;
      len_r   <= '0;
      left_r  <= '0;
      crc_r   <= CRC_INIT;
      trl_r   <= '0;
      gap_r   <= '0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      crc_r   <= crc_nxt;
      trl_r   <= trl_nxt;
      gap_r   <= gap_nxt;
    end
  end

  // Gap timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= GAP_TIMEOUT_DEFAULT;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

`ifndef NO_ASSERTIONS
  // Frame end flag matches the result kind
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.frame_done == (res.out_kind != KIND_DATA)))
    else $error("frame_done disagrees with result kind");

  // Gap counter stays clear while hunting
  a_hunt_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (gap_r == '0))
    else $error("gap counter running while hunting");

  // A finished or aborted frame sends the parser back to hunting
  a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && res_valid && res.frame_done) |=> (phase_r == PH_HUNT))
    else $error("parser not hunting after frame end");

  // Payload words only come out of the payload phase
  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.out_kind == KIND_DATA) |-> (phase_r == PH_PAYLOAD))
    else $error("payload word outside payload phase");
`endif

endmodule

`default_nettype wire

### hdl/ufrc_out_reg.sv
// ----------------------------------------------------------------------------
// ufrc_out_reg
// Result register: holds one result word for the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrc_out_reg
  import ufrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         res_ready,
  output logic         out_valid,
  output result_t      out_res,
  input  wire logic    out_ready
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Take a new word when empty or when the held one drains
  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire
